/* src/bc_texture_vertical_flip_macros.svh */
// Assertion macros used by the block's position counter module
`ifndef BC_TEXTURE_VERTICAL_FLIP_MACROS_SVH
`define BC_TEXTURE_VERTICAL_FLIP_MACROS_SVH

// Check cons in the same cycle as ante
`define BCTVF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bctvf assertion failed");

// Check cons in the cycle after ante
`define BCTVF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bctvf assertion failed");

`endif

/* src/bctvf_pkg.sv */
// Shared types and constants for the compressed block vertical flip
package bctvf_pkg;

    localparam int BLOCK_W    = 64;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int DIM_W      = 15;
    localparam int DEST_W     = 24;

    typedef enum logic [2:0] {
        FMT_REORDER = 3'd0,
        FMT_BC1     = 3'd1,
        FMT_BC2     = 3'd2,
        FMT_BC3     = 3'd3,
        FMT_BC4     = 3'd4,
        FMT_BC5     = 3'd5
    } t_fmt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLOCK_FORMAT  = 2'd0,
        CFG_IMAGE_WIDTH   = 2'd1,
        CFG_IMAGE_HEIGHT  = 2'd2,
        CFG_MIRROR_ENABLE = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] fmt;
        logic       mirror;
    } t_mode;

endpackage

/* src/bctvf_cfg.sv */
// Configuration registers and derived block grid size
module bctvf_cfg #(
    parameter int MAX_DIMENSION = 16384,
    parameter int CNT_W         = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bctvf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bctvf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bctvf_pkg::t_mode                o_mode,
    output logic [CNT_W-1:0]                o_cols,
    output logic [CNT_W-1:0]                o_rows,
    output logic                            o_restart
);
    import bctvf_pkg::*;

    localparam int DIM_CAP = (MAX_DIMENSION < 32767) ? MAX_DIMENSION : 32767;
    localparam logic [DIM_W-1:0] DIM_CAP_V = DIM_W'(DIM_CAP);

    logic [2:0]       r_fmt,       n_fmt;
    logic             r_mirror_en, n_mirror_en;
    logic             r_tall,      n_tall;
    logic [CNT_W-1:0] r_cols,      n_cols;
    logic [CNT_W-1:0] r_rows,      n_rows;

    function automatic logic [CNT_W-1:0] blocks_of(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] dc;
        logic [DIM_W:0]   sum;
        begin
            if (d == '0) begin
                dc = DIM_W'(1);
            end else if (d > DIM_CAP_V) begin
                dc = DIM_CAP_V;
            end else begin
                dc = d;
            end
            sum = {1'b0, dc} + (DIM_W+1)'(3);
            blocks_of = sum[CNT_W+1:2];
        end
    endfunction

    always_comb begin
        n_fmt       = r_fmt;
        n_mirror_en = r_mirror_en;
        n_tall      = r_tall;
        n_cols      = r_cols;
        n_rows      = r_rows;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLOCK_FORMAT: begin
                    n_fmt = i_cfg_data[2:0];
                end
                CFG_IMAGE_WIDTH: begin
                    n_cols = blocks_of(i_cfg_data[DIM_W-1:0]);
                end
                CFG_IMAGE_HEIGHT: begin
                    n_rows = blocks_of(i_cfg_data[DIM_W-1:0]);
                    n_tall = (i_cfg_data[DIM_W-1:0] >= DIM_W'(2));
                end
                CFG_MIRROR_ENABLE: begin
                    n_mirror_en = i_cfg_data[0];
                end
                default: begin
                    n_fmt = r_fmt;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt       <= FMT_BC1;
            r_mirror_en <= 1'b1;
            r_tall      <= 1'b0;
            r_cols      <= CNT_W'(1);
            r_rows      <= CNT_W'(1);
        end else begin
            r_fmt       <= n_fmt;
            r_mirror_en <= n_mirror_en;
            r_tall      <= n_tall;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
        end
    end

    assign o_mode.fmt    = r_fmt;
    assign o_mode.mirror = r_mirror_en & r_tall;
    assign o_cols        = r_cols;
    assign o_rows        = r_rows;
    assign o_restart     = i_cfg_we;

endmodule

/* src/bctvf_flip.sv */
// Per-format vertical mirror of one compressed block
module bctvf_flip (
    input  bctvf_pkg::t_mode               i_mode,
    input  logic [bctvf_pkg::BLOCK_W-1:0]  i_block_low,
    input  logic [bctvf_pkg::BLOCK_W-1:0]  i_block_high,
    output logic [bctvf_pkg::BLOCK_W-1:0]  o_flipped_low,
    output logic [bctvf_pkg::BLOCK_W-1:0]  o_flipped_high
);
    import bctvf_pkg::*;

    function automatic logic [BLOCK_W-1:0] flip_colour(input logic [BLOCK_W-1:0] w);
        logic [BLOCK_W-1:0] res;
        begin
            res = w;
            for (int k = 0; k < 4; k++) begin
                res[32 + 8*(3-k) +: 8] = w[32 + 8*k +: 8];
            end
            flip_colour = res;
        end
    endfunction

    function automatic logic [BLOCK_W-1:0] flip_explicit(input logic [BLOCK_W-1:0] w);
        logic [BLOCK_W-1:0] res;
        begin
            res = '0;
            for (int k = 0; k < 4; k++) begin
                res[16*(3-k) +: 16] = w[16*k +: 16];
            end
            flip_explicit = res;
        end
    endfunction

    function automatic logic [BLOCK_W-1:0] flip_interp(input logic [BLOCK_W-1:0] w);
        logic [BLOCK_W-1:0] res;
        begin
            res = w;
            for (int k = 0; k < 4; k++) begin
                res[16 + 12*(3-k) +: 12] = w[16 + 12*k +: 12];
            end
            flip_interp = res;
        end
    endfunction

    always_comb begin
        o_flipped_low  = i_block_low;
        o_flipped_high = i_block_high;
        if (i_mode.mirror) begin
            unique case (i_mode.fmt)
                FMT_BC1: begin
                    o_flipped_low = flip_colour(i_block_low);
                end
                FMT_BC2: begin
                    o_flipped_low  = flip_explicit(i_block_low);
                    o_flipped_high = flip_colour(i_block_high);
                end
                FMT_BC3: begin
                    o_flipped_low  = flip_interp(i_block_low);
                    o_flipped_high = flip_colour(i_block_high);
                end
                FMT_BC4: begin
                    o_flipped_low = flip_interp(i_block_low);
                end
                FMT_BC5: begin
                    o_flipped_low  = flip_interp(i_block_low);
                    o_flipped_high = flip_interp(i_block_high);
                end
                default: begin
                    o_flipped_low = i_block_low;
                end
            endcase
        end
    end

endmodule

/* src/bctvf_pos.sv */
// Block position counters and destination index
`include "bc_texture_vertical_flip_macros.svh"

module bctvf_pos #(
    parameter int CNT_W = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_advance,
    input  logic                          i_mirror,
    input  logic [CNT_W-1:0]              i_cols,
    input  logic [CNT_W-1:0]              i_rows,
    output logic [bctvf_pkg::DEST_W-1:0]  o_dest_block_index,
    output logic                          o_last
);
    import bctvf_pkg::*;

    localparam int PROD_W = 2 * CNT_W;
    localparam int SUM_W  = (PROD_W + 1 > DEST_W) ? PROD_W + 1 : DEST_W;

    logic [CNT_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_row, n_row;
    logic [CNT_W-1:0]  dest_row;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  idx_full;
    logic              col_end;
    logic              row_end;

    assign col_end  = (r_col == i_cols - CNT_W'(1));
    assign row_end  = (r_row == i_rows - CNT_W'(1));
    assign dest_row = i_mirror ? (i_rows - CNT_W'(1) - r_row) : r_row;
    assign prod     = PROD_W'(dest_row) * PROD_W'(i_cols);
    assign idx_full = SUM_W'(prod) + SUM_W'(r_col);

    assign o_dest_block_index = idx_full[DEST_W-1:0];
    assign o_last             = col_end & row_end;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `BCTVF_ASSERT_NOW(a_col_in_range, i_clk, i_rst_n, 1'b1, r_col < i_cols)
    `BCTVF_ASSERT_NOW(a_row_in_range, i_clk, i_rst_n, 1'b1, r_row < i_rows)
    `BCTVF_ASSERT_NEXT(a_restart_zero, i_clk, i_rst_n, i_restart, r_col == '0 && r_row == '0)
    `BCTVF_ASSERT_NEXT(a_last_wraps, i_clk, i_rst_n, i_advance && o_last, r_col == '0 && r_row == '0)

endmodule

/* src/bc_texture_vertical_flip.sv */
// An accepted item's result appears on the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the output register takes a new item whenever
// it is empty or its result is taken in the same cycle.
// Position counters and the destination index multiply sit before the output register.
// Reset (synchronous, active low) empties the output and sets BC1, 1x1, mirror enable on.
// A configuration write restarts the level at block column 0, row 0.
module bc_texture_vertical_flip #(
    parameter int MAX_DIMENSION = 16384
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [bctvf_pkg::BLOCK_W-1:0]    i_block_low,
    input  logic [bctvf_pkg::BLOCK_W-1:0]    i_block_high,
    input  logic                            i_cfg_we,
    input  logic [bctvf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bctvf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bctvf_pkg::BLOCK_W-1:0]    o_flipped_low,
    output logic [bctvf_pkg::BLOCK_W-1:0]    o_flipped_high,
    output logic [bctvf_pkg::DEST_W-1:0]     o_dest_block_index,
    output logic                            o_image_done
);
    import bctvf_pkg::*;

    localparam int DIM_CAP  = (MAX_DIMENSION < 32767) ? MAX_DIMENSION : 32767;
    localparam int COLS_MAX = (DIM_CAP + 3) / 4;
    localparam int CNT_W    = $clog2(COLS_MAX + 1);

    t_mode              mode;
    logic [CNT_W-1:0]   cols;
    logic [CNT_W-1:0]   rows;
    logic               restart;
    logic               accept;
    logic [BLOCK_W-1:0] flip_low;
    logic [BLOCK_W-1:0] flip_high;
    logic [DEST_W-1:0]  dest_idx;
    logic               last;

    logic               r_valid,     n_valid;
    logic [BLOCK_W-1:0] r_low;
    logic [BLOCK_W-1:0] r_high;
    logic [DEST_W-1:0]  r_dest;
    logic               r_done;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    bctvf_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .CNT_W         (CNT_W)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_mode      (mode),
        .o_cols      (cols),
        .o_rows      (rows),
        .o_restart   (restart)
    );

    bctvf_flip u_flip (
        .i_mode         (mode),
        .i_block_low    (i_block_low),
        .i_block_high   (i_block_high),
        .o_flipped_low  (flip_low),
        .o_flipped_high (flip_high)
    );

    bctvf_pos #(
        .CNT_W (CNT_W)
    ) u_pos (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_restart          (restart),
        .i_advance          (accept),
        .i_mirror           (mode.mirror),
        .i_cols             (cols),
        .i_rows             (rows),
        .o_dest_block_index (dest_idx),
        .o_last             (last)
    );

    always_comb begin
        n_valid = r_valid & i_stall;
        if (accept) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_low  <= flip_low;
            r_high <= flip_high;
            r_dest <= dest_idx;
            r_done <= last;
        end
    end

    assign o_valid            = r_valid;
    assign o_flipped_low      = r_low;
    assign o_flipped_high     = r_high;
    assign o_dest_block_index = r_dest;
    assign o_image_done       = r_done;

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the compressed block vertical flip with destination indexing
module tb;
    import bctvf_pkg::*;

    localparam int MAX_DIM     = 16384;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_BLOCKS = 650;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [23:0] dest;
        logic        done;
    } t_flip_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [BLOCK_W-1:0]    i_block_low = '0;
    logic [BLOCK_W-1:0]    i_block_high = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [BLOCK_W-1:0]    o_flipped_low;
    logic [BLOCK_W-1:0]    o_flipped_high;
    logic [DEST_W-1:0]     o_dest_block_index;
    logic                  o_image_done;

    t_block       blocks_to_send[$];
    t_flip_result flips_due[$];

    logic [2:0]   lvl_format;
    logic [14:0]  lvl_width;
    logic [14:0]  lvl_height;
    logic         lvl_mirror;
    int unsigned  blk_col;
    int unsigned  blk_row;

    int n_blocks;
    int n_results;
    int n_done;
    int n_levels;
    int n_errors;
    int quiet_cycles;

    bc_texture_vertical_flip #(
        .MAX_DIMENSION (MAX_DIM)
    ) u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_block_low        (i_block_low),
        .i_block_high       (i_block_high),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_flipped_low      (o_flipped_low),
        .o_flipped_high     (o_flipped_high),
        .o_dest_block_index (o_dest_block_index),
        .o_image_done       (o_image_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned clamp_dim(input logic [14:0] d);
        if (d == 0) begin
            return 1;
        end
        if (d > MAX_DIM) begin
            return MAX_DIM;
        end
        return d;
    endfunction

    function automatic logic [63:0] flip_colour(input logic [63:0] w);
        logic [63:0] r;
        r = w;
        for (int k = 0; k < 4; k++) begin
            r[32 + 8 * (3 - k) +: 8] = w[32 + 8 * k +: 8];
        end
        return r;
    endfunction

    function automatic logic [63:0] flip_alpha_rows(input logic [63:0] w);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            r[16 * (3 - k) +: 16] = w[16 * k +: 16];
        end
        return r;
    endfunction

    function automatic logic [63:0] flip_index_rows(input logic [63:0] w);
        logic [63:0] r;
        r = w;
        for (int k = 0; k < 4; k++) begin
            r[16 + 12 * (3 - k) +: 12] = w[16 + 12 * k +: 12];
        end
        return r;
    endfunction

    function automatic t_flip_result predict_flip(input t_block b);
        int unsigned  w;
        int unsigned  h;
        int unsigned  cols;
        int unsigned  rows;
        int unsigned  drow;
        logic         mir;
        t_flip_result r;
        w    = clamp_dim(lvl_width);
        h    = clamp_dim(lvl_height);
        cols = (w + 3) / 4;
        rows = (h + 3) / 4;
        mir  = lvl_mirror && (h >= 2);
        r.lo = b.lo;
        r.hi = b.hi;
        drow = blk_row;
        if (mir) begin
            case (t_fmt'(lvl_format))
                FMT_BC1: r.lo = flip_colour(b.lo);
                FMT_BC2: begin
                    r.lo = flip_alpha_rows(b.lo);
                    r.hi = flip_colour(b.hi);
                end
                FMT_BC3: begin
                    r.lo = flip_index_rows(b.lo);
                    r.hi = flip_colour(b.hi);
                end
                FMT_BC4: r.lo = flip_index_rows(b.lo);
                FMT_BC5: begin
                    r.lo = flip_index_rows(b.lo);
                    r.hi = flip_index_rows(b.hi);
                end
                default: ;
            endcase
            drow = rows - 1 - blk_row;
        end
        r.done = (blk_row == rows - 1) && (blk_col == cols - 1);
        r.dest = 24'(drow * cols + blk_col);
        if (blk_col + 1 >= cols) begin
            blk_col = 0;
            blk_row = (blk_row + 1 >= rows) ? 0 : blk_row + 1;
        end else begin
            blk_col = blk_col + 1;
        end
        return r;
    endfunction

    // driver and predictor
    always @(posedge i_clk) begin : drive
        t_block b;
        int     idle_pct;
        idle_pct = (n_blocks < 225) ? 32 : (n_blocks < 450) ? 45 : 0;
        if (!i_rst_n) begin
            lvl_format = FMT_BC1;
            lvl_width  = 15'd1;
            lvl_height = 15'd1;
            lvl_mirror = 1'b1;
            blk_col    = 0;
            blk_row    = 0;
            i_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_BLOCK_FORMAT:  lvl_format = i_cfg_data[2:0];
                    CFG_IMAGE_WIDTH:   lvl_width  = i_cfg_data;
                    CFG_IMAGE_HEIGHT:  lvl_height = i_cfg_data;
                    CFG_MIRROR_ENABLE: lvl_mirror = i_cfg_data[0];
                    default: ;
                endcase
                blk_col = 0;
                blk_row = 0;
            end
            if (i_valid && !o_stall) begin
                flips_due.push_back(predict_flip({i_block_low, i_block_high}));
                n_blocks++;
            end
            if (!i_valid || !o_stall) begin
                if (blocks_to_send.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    b = blocks_to_send.pop_front();
                    i_valid      <= 1'b1;
                    i_block_low  <= b.lo;
                    i_block_high <= b.hi;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin : monitor
        t_flip_result want;
        int           idle_pct;
        idle_pct = (n_blocks < 225) ? 45 : (n_blocks < 450) ? 32 : 0;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (flips_due.size() == 0) begin
                $display("%0t: unexpected item dest=%0d lo=%h hi=%h", $time,
                         o_dest_block_index, o_flipped_low, o_flipped_high);
                n_errors++;
            end else begin
                want = flips_due.pop_front();
                n_results++;
                if (o_image_done === 1'b1) begin
                    n_done++;
                end
                if (o_flipped_low !== want.lo) begin
                    $display("%0t: flipped_low expected %h actual %h", $time,
                             want.lo, o_flipped_low);
                    n_errors++;
                end
                if (o_flipped_high !== want.hi) begin
                    $display("%0t: flipped_high expected %h actual %h", $time,
                             want.hi, o_flipped_high);
                    n_errors++;
                end
                if (o_dest_block_index !== want.dest) begin
                    $display("%0t: dest_block_index expected %0d actual %0d", $time,
                             want.dest, o_dest_block_index);
                    n_errors++;
                end
                if (o_image_done !== want.done) begin
                    $display("%0t: image_done expected %0d actual %0d", $time,
                             want.done, o_image_done);
                    n_errors++;
                end
            end
        end
        i_stall <= ($urandom_range(0, 99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid === 1'b1 && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [14:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_level(input logic [2:0] fmt, input logic [14:0] w,
                             input logic [14:0] h, input logic mir);
        write_reg(CFG_BLOCK_FORMAT, {12'd0, fmt});
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_MIRROR_ENABLE, {14'd0, mir});
        n_levels++;
    endtask

    task automatic push_block(input logic [63:0] lo, input logic [63:0] hi);
        t_block b;
        b.lo = lo;
        b.hi = hi;
        blocks_to_send.push_back(b);
    endtask

    // hold until every item has been sent and every result has come back
    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (blocks_to_send.size() != 0 || i_valid || flips_due.size() != 0);
    endtask

    function automatic logic [14:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0: return 15'd0;
            1: return 15'd16384;
            2: return 15'd32767;
            3: return 15'($urandom);
            4: return 15'd16385;
            default: return 15'($urandom_range(1, 40));
        endcase
    endfunction

    localparam logic [63:0] RAMP_LO = 64'h0706_0504_0302_0100;
    localparam logic [63:0] RAMP_HI = 64'h0F0E_0D0C_0B0A_0908;
    localparam logic [63:0] ALT_A   = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [63:0] ALT_5   = 64'h5555_5555_5555_5555;

    initial begin
        int          n_random;
        int          cnt;
        int unsigned blocks;
        int unsigned sel;
        logic [14:0] w;
        logic [14:0] h;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: BC1, 1x1, so blocks pass through
        push_block('1, '1);
        push_block(RAMP_LO, RAMP_HI);
        drain();

        for (int f = 0; f < 8; f++) begin
            set_level(3'(f), 15'd4, 15'd8, 1'b1);
            push_block(RAMP_LO, RAMP_HI);
            if (f % 2 == 1) begin
                push_block('1, '0);
            end else begin
                push_block(ALT_A, ALT_5);
            end
            drain();
        end

        set_level(FMT_BC3, 15'd0, 15'd0, 1'b1);
        push_block(RAMP_LO, RAMP_HI);
        drain();

        set_level(FMT_BC5, 15'd32767, 15'd32767, 1'b1);
        push_block(RAMP_LO, RAMP_HI);
        push_block(ALT_5, ALT_A);
        drain();

        set_level(FMT_BC2, 15'd8, 15'd8, 1'b0);
        for (int k = 0; k < 4; k++) begin
            push_block(RAMP_LO, RAMP_HI);
        end
        drain();

        n_random = 0;
        while (n_random < RANDOM_BLOCKS) begin
            w = pick_dim();
            h = pick_dim();
            set_level(3'($urandom_range(0, 7)), w, h, $urandom_range(0, 9) != 0);
            blocks = ((clamp_dim(w) + 3) / 4) * ((clamp_dim(h) + 3) / 4);
            if (blocks <= 40) begin
                cnt = $urandom_range(1, 2 * blocks + 2);
            end else begin
                cnt = $urandom_range(1, 24);
            end
            for (int k = 0; k < cnt; k++) begin
                sel = $urandom_range(0, 15);
                if (sel == 0) begin
                    push_block('1, '1);
                end else if (sel == 1) begin
                    push_block('0, '0);
                end else begin
                    push_block({$urandom, $urandom}, {$urandom, $urandom});
                end
            end
            n_random += cnt;
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("run: %0d blocks over %0d level settings, %0d results checked,",
                 n_blocks, n_levels, n_results);
        $display("run: %0d level ends seen, %0d mismatches", n_done, n_errors);
        if (n_errors == 0 && flips_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
